>>> sv/irau_pkg.sv
// shared constants and types for the interval room allocator
package irau_pkg;

  localparam int ROOMS     = 64;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int NUM_W     = $clog2(ROOMS + 1);
  localparam int OUT_W     = 7;
  localparam int IN_DATA_W  = 2 * TIME_BITS;
  localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * OUT_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ROOMS-1:0]     room_vec_t;

  // request presented to the room bank
  typedef struct packed {
    logic  fire;
    logic  batch;
    time_t arrival;
    time_t departure;
  } room_req_t;

  // choice of the lowest free room
  typedef struct packed {
    logic             have;
    room_vec_t        onehot;
    logic [IDX_W-1:0] idx;
  } room_pick_t;

endpackage

>>> sv/irau_bank.sv
// room occupancy and departure registers with parallel release compare
module irau_bank
  import irau_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  room_req_t  req,
  input  room_pick_t pick,
  output room_vec_t  free_vec
);

  room_vec_t busy_r;
  room_vec_t busy_nxt;
  room_vec_t busy_eff;
  time_t     dep_r [ROOMS];

  always_comb begin
    for (int i = 0; i < ROOMS; i++) begin
      busy_eff[i] = busy_r[i] && !req.batch && !(dep_r[i] < req.arrival);
      free_vec[i] = !busy_eff[i];
      busy_nxt[i] = busy_eff[i] | pick.onehot[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (req.fire) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOMS; i++) begin
      if (req.fire && pick.onehot[i] && pick.have) begin
        dep_r[i] <= req.departure;
      end
    end
  end

endmodule

>>> sv/irau_pick.sv
// lowest free room priority encoder
module irau_pick
  import irau_pkg::*;
(
  input  room_vec_t  free_vec,
  output room_pick_t pick
);

  room_vec_t low;

  always_comb begin
    low         = free_vec & (~free_vec + room_vec_t'(1));
    pick.have   = |free_vec;
    pick.onehot = low;
    pick.idx    = '0;
    for (int i = 0; i < ROOMS; i++) begin
      if (low[i]) begin
        pick.idx = pick.idx | IDX_W'(i);
      end
    end
  end

endmodule

>>> sv/interval_room_allocator_unit.sv
// top level of the interval room allocator
// Each request (arrival in in_tdata low word, departure in the high word, new batch in
// in_tuser) passes through one input register and one result register, and one request is
// accepted every cycle while out_tready does not stall the result register.
// Within the step all room departures are compared with the arrival in parallel and a
// priority encoder picks the lowest free room, so that compare and encode set the clock
// period. Room numbers start at 1; overflow in out_tuser marks a request with no room.
module interval_room_allocator_unit
  import irau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // arrival_time, departure_time
  input  logic                   in_tuser,  // new_batch
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // room_number, rooms_used, zero pad
  output logic                   out_tuser  // overflow
);

  logic             s_v_r;
  time_t            s_arr_r;
  time_t            s_dep_r;
  logic             s_batch_r;
  logic             o_v_r;
  logic [OUT_W-1:0] o_room_r;
  logic [OUT_W-1:0] o_used_r;
  logic             o_ovf_r;
  logic [NUM_W-1:0] max_r;
  logic [NUM_W-1:0] max_nxt;
  logic [NUM_W-1:0] max_base;
  logic [NUM_W-1:0] num;
  logic             out_free;
  logic             fire;
  logic             in_xfer;
  room_req_t        req;
  room_pick_t       pick;
  room_vec_t        free_vec;

  assign out_free  = !o_v_r || out_tready;
  assign fire      = s_v_r && out_free;
  assign in_tready = !s_v_r || fire;
  assign in_xfer   = in_tvalid && in_tready;

  assign req.fire      = fire;
  assign req.batch     = s_batch_r;
  assign req.arrival   = s_arr_r;
  assign req.departure = s_dep_r;

  irau_bank u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .pick     (pick),
    .free_vec (free_vec)
  );

  irau_pick u_pick (
    .free_vec (free_vec),
    .pick     (pick)
  );

  always_comb begin
    num      = NUM_W'(pick.idx) + NUM_W'(1);
    max_base = s_batch_r ? '0 : max_r;
    max_nxt  = (pick.have && (num > max_base)) ? num : max_base;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_tready) begin
      s_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_arr_r   <= in_tdata[TIME_BITS-1:0];
      s_dep_r   <= in_tdata[2*TIME_BITS-1:TIME_BITS];
      s_batch_r <= in_tuser;
    end
  end

  // result register and running maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      max_r <= '0;
    end else begin
      if (out_free) begin
        o_v_r <= s_v_r;
      end
      if (fire) begin
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_room_r <= pick.have ? OUT_W'(num) : '0;
      o_used_r <= OUT_W'(max_nxt);
      o_ovf_r  <= !pick.have;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_ovf_r;
  assign out_tdata  = OUT_TDATA_W'({o_used_r, o_room_r});

  a_pick_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    fire && pick.have |-> $onehot(pick.onehot) && free_vec[pick.idx])
    else $error("picked room is not a single free room");

  a_room_bound : assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !o_ovf_r |-> (o_room_r != '0) && (o_room_r <= o_used_r))
    else $error("placed room is zero or above rooms used");

  a_ovf_room : assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && o_ovf_r |-> (o_room_r == '0))
    else $error("overflow result carries a room");

  a_fire_result : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> o_v_r)
    else $error("processed request left no result");

endmodule
